>>> hw/rtl/rv2d_pkg.sv
// Shared types and constants for the 2D vector rotation pipeline.
// Holds the Q30 formats, the Horner divisor table and the pipeline depths.
// No dependencies.
package rv2d_pkg;

	// fraction bits of the internal sine/cosine and phase formats
	localparam int unsigned FRAC_W = 30;

	// 1.0 in Q30 (31 bits so that it fits), half of 1.0, and pi/2 in Q30
	localparam logic [FRAC_W:0]   Q30_ONE     = 31'h4000_0000;
	localparam logic [FRAC_W-1:0] HALF_Q30    = 30'h2000_0000;
	localparam logic [FRAC_W:0]   HALF_PI_Q30 = 31'd1686629713;

	// Horner steps of each series and the stages they take
	localparam int unsigned SIN_STEPS  = 5;
	localparam int unsigned COS_STEPS  = 6;
	localparam int unsigned STEP_STG   = 3;
	localparam int unsigned HORNER_LAT = STEP_STG * COS_STEPS;

	// accepting edge to the edge that takes the result
	localparam int unsigned LATENCY = HORNER_LAT + 6;

	// control that travels beside the sine/cosine lanes
	typedef struct packed {
		logic       vld;
		logic [1:0] quad;
		logic       swap;
	} ctl_t;

	// divisor of Horner step idx for the sine or the cosine series
	function automatic int unsigned horner_div(input logic sine, input int unsigned idx);
		int unsigned k;
		k = 2;
		if (sine) begin
			case (idx)
				0:       k = 110;
				1:       k = 72;
				2:       k = 42;
				3:       k = 20;
				default: k = 6;
			endcase
		end else begin
			case (idx)
				0:       k = 132;
				1:       k = 90;
				2:       k = 56;
				3:       k = 30;
				4:       k = 12;
				default: k = 2;
			endcase
		end
		return k;
	endfunction

endpackage

>>> hw/rtl/vector_rotate_2d_core.sv
// Rotates a signed Q8.8 vector counter-clockwise by a binary angle.
//
// Input channel: drive vec_x, vec_y and angle with start high; the item is taken
// at any rising edge where start is high and busy is low. busy stays low, so an
// item can be taken on every clock.
// Output channel: done is high for exactly one cycle with rot_x/rot_y (Q9.8,
// rounded half up) valid in that cycle; the receiver must take it then.
// Order: each item passes the input register, the radian and square stages, the
// Horner lanes and the apply stages; results leave in the order items were taken.
// Throughput: one item per clock. The pipeline has 24 register stages; its depth
// is set by the cosine series, six Horner steps of three stages each
// (multiply, reciprocal multiply, correct), run beside the sine series.
// Reset (arst_n low) clears all valid bits: items in flight are dropped and no
// done pulse follows. No state outlives an item, so nothing else needs reset.
// Depends on rv2d_pkg, rv2d_delay, rv2d_horner and rv2d_apply.
module vector_rotate_2d_core #(
	parameter int unsigned COORD_WIDTH = 16,
	parameter int unsigned ANGLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] vec_x,
	input  logic signed [COORD_WIDTH-1:0] vec_y,
	input  logic [ANGLE_WIDTH-1:0]        angle,
	output logic                          done,
	output logic signed [COORD_WIDTH:0]   rot_x,
	output logic signed [COORD_WIDTH:0]   rot_y
);
	import rv2d_pkg::*;

	localparam int unsigned PhShift  = 32 - ANGLE_WIDTH;
	localparam int unsigned ProdW    = 2 * FRAC_W + 1;
	localparam int unsigned VldDepth = HORNER_LAT + 3;
	localparam int unsigned SideW    = 2 * COORD_WIDTH + 3;
	localparam int unsigned SideDly  = HORNER_LAT + 2;
	localparam int unsigned TDly     = STEP_STG * SIN_STEPS;
	localparam int unsigned SinPad   = HORNER_LAT - STEP_STG * SIN_STEPS - 1;

	logic                accept;
	logic [VldDepth-1:0] vld_q;

	logic [31:0]       phase;
	logic [FRAC_W-1:0] u_in;
	logic              swap_in;
	logic [FRAC_W-1:0] v_in;
	logic [ProdW-1:0]  prod_t;
	logic [ProdW-1:0]  prod_t2;
	logic [ProdW-1:0]  prod_s;

	logic signed [COORD_WIDTH-1:0] x_s1;
	logic signed [COORD_WIDTH-1:0] y_s1;
	logic [1:0]                    quad_s1;
	logic                          swap_s1;
	logic [FRAC_W-1:0]             v_s1;
	logic [FRAC_W-1:0]             t_s2;
	logic [FRAC_W-1:0]             t_s3;
	logic [FRAC_W-1:0]             t2_s3;
	logic [FRAC_W-1:0]             t_s18;
	logic [FRAC_W:0]               sin_a_s18;
	logic [FRAC_W-1:0]             sin_s19;
	logic [FRAC_W-1:0]             sin_s21;
	logic [FRAC_W:0]               cos_s21;
	logic [SideW-1:0]              side_s21;
	logic signed [COORD_WIDTH-1:0] x_s21;
	logic signed [COORD_WIDTH-1:0] y_s21;
	ctl_t                          ctl_s21;

	// never stall the input: the pipeline advances every cycle
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// carry one valid bit per stage up to the mapping stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[VldDepth-2:0], accept};
		end
	end

	// split the phase into quadrant and fold the in-quadrant part to one octant
	always_comb begin
		phase   = 32'(angle) << PhShift;
		u_in    = phase[FRAC_W-1:0];
		swap_in = u_in > HALF_Q30;
		v_in    = swap_in ? FRAC_W'(Q30_ONE - (FRAC_W+1)'(u_in)) : u_in;
	end

	always_ff @(posedge clk) begin
		x_s1    <= vec_x;
		y_s1    <= vec_y;
		quad_s1 <= phase[31:30];
		swap_s1 <= swap_in;
		v_s1    <= v_in;
	end

	// convert to radians in Q30, rounded
	assign prod_t = ProdW'(v_s1) * ProdW'(HALF_PI_Q30) + ProdW'(HALF_Q30);

	always_ff @(posedge clk) begin
		t_s2 <= prod_t[2*FRAC_W-1:FRAC_W];
	end

	// square the angle for both series
	assign prod_t2 = ProdW'(t_s2) * ProdW'(t_s2);

	always_ff @(posedge clk) begin
		t_s3  <= t_s2;
		t2_s3 <= prod_t2[2*FRAC_W-1:FRAC_W];
	end

	rv2d_horner #(
		.STEPS (SIN_STEPS),
		.SINE  (1'b1)
	) u_sin (
		.clk   (clk),
		.t2_in (t2_s3),
		.a_out (sin_a_s18)
	);

	rv2d_horner #(
		.STEPS (COS_STEPS),
		.SINE  (1'b0)
	) u_cos (
		.clk   (clk),
		.t2_in (t2_s3),
		.a_out (cos_s21)
	);

	// hold t until the sine series is done, then apply its final factor
	rv2d_delay #(
		.WIDTH (FRAC_W),
		.DEPTH (TDly)
	) u_t_dly (
		.clk (clk),
		.d   (t_s3),
		.q   (t_s18)
	);

	assign prod_s = ProdW'(t_s18) * ProdW'(sin_a_s18);

	always_ff @(posedge clk) begin
		sin_s19 <= prod_s[2*FRAC_W-1:FRAC_W];
	end

	// align the sine with the longer cosine lane
	rv2d_delay #(
		.WIDTH (FRAC_W),
		.DEPTH (SinPad)
	) u_sin_dly (
		.clk (clk),
		.d   (sin_s19),
		.q   (sin_s21)
	);

	// carry the vector and the quadrant info beside the lanes
	rv2d_delay #(
		.WIDTH (SideW),
		.DEPTH (SideDly)
	) u_side_dly (
		.clk (clk),
		.d   ({x_s1, y_s1, quad_s1, swap_s1}),
		.q   (side_s21)
	);

	always_comb begin
		x_s21        = side_s21[SideW-1:COORD_WIDTH+3];
		y_s21        = side_s21[COORD_WIDTH+2:3];
		ctl_s21.vld  = vld_q[VldDepth-1];
		ctl_s21.quad = side_s21[2:1];
		ctl_s21.swap = side_s21[0];
	end

	rv2d_apply #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_apply (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s21),
		.x      (x_s21),
		.y      (y_s21),
		.sin_in ({1'b0, sin_s21}),
		.cos_in (cos_s21),
		.strobe (done),
		.rot_x  (rot_x),
		.rot_y  (rot_y)
	);

endmodule

>>> hw/rtl/rv2d_delay.sv
// Fixed-length register delay line for payload that rides beside the pipeline.
// Standalone; no package needed.
module rv2d_delay #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] pipe_q [DEPTH];

	// advance every tap each cycle
	always_ff @(posedge clk) begin
		pipe_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[DEPTH-1];

endmodule

>>> hw/rtl/rv2d_horner.sv
// One Horner lane of the sine or cosine series, three register stages per step:
// multiply by t^2, divide by the step constant via reciprocal, correct and subtract.
// Depends on rv2d_pkg.
module rv2d_horner #(
	parameter int unsigned STEPS = 6,
	parameter bit          SINE  = 1'b0
) (
	input  logic                        clk,
	input  logic [rv2d_pkg::FRAC_W-1:0] t2_in,
	output logic [rv2d_pkg::FRAC_W:0]   a_out
);
	import rv2d_pkg::*;

	localparam int unsigned ProdW = 2 * FRAC_W + 1;

	logic [FRAC_W:0]   a_chain  [STEPS+1];
	logic [FRAC_W-1:0] t2_chain [STEPS];

	assign a_chain[0]  = Q30_ONE;
	assign t2_chain[0] = t2_in;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int unsigned     Div   = horner_div(SINE, i);
		localparam logic [FRAC_W-1:0] DivV  = FRAC_W'(Div);
		localparam logic [FRAC_W-1:0] Recip = FRAC_W'((2 ** FRAC_W) / Div);

		logic [ProdW-1:0]  prod_a;
		logic [ProdW-1:0]  prod_b;
		logic [FRAC_W-1:0] back;
		logic [FRAC_W-1:0] rem;
		logic [FRAC_W-1:0] quo;
		logic [FRAC_W-1:0] m_s1;
		logic [FRAC_W-1:0] m_s2;
		logic [FRAC_W-1:0] qe_s2;
		logic [FRAC_W:0]   a_s3;

		// scale the running term by t^2 and drop the Q30 fraction
		assign prod_a = ProdW'(t2_chain[i]) * ProdW'(a_chain[i]);

		always_ff @(posedge clk) begin
			m_s1 <= prod_a[2*FRAC_W-1:FRAC_W];
		end

		// estimate the quotient; it is exact or one short
		assign prod_b = ProdW'(m_s1) * ProdW'(Recip);

		always_ff @(posedge clk) begin
			qe_s2 <= prod_b[2*FRAC_W-1:FRAC_W];
			m_s2  <= m_s1;
		end

		// fix a short estimate and form the next term
		always_comb begin
			back = qe_s2 * DivV;
			rem  = m_s2 - back;
			quo  = qe_s2 + FRAC_W'(rem >= DivV);
		end

		always_ff @(posedge clk) begin
			a_s3 <= Q30_ONE - (FRAC_W+1)'(quo);
		end

		assign a_chain[i+1] = a_s3;

		// hold t^2 beside the term for the next step
		if (i + 1 < STEPS) begin : g_fwd
			logic [FRAC_W-1:0] t2_s1;
			logic [FRAC_W-1:0] t2_s2;
			logic [FRAC_W-1:0] t2_s3;
			always_ff @(posedge clk) begin
				t2_s1 <= t2_chain[i];
				t2_s2 <= t2_s1;
				t2_s3 <= t2_s2;
			end
			assign t2_chain[i+1] = t2_s3;
		end
	end

	assign a_out = a_chain[STEPS];

endmodule

>>> hw/rtl/rv2d_apply.sv
// Output end of the rotation: quadrant mapping, the four products, sum and rounding.
// Three register stages; the last one drives the result ports. Depends on rv2d_pkg.
module rv2d_apply #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rv2d_pkg::ctl_t                    ctl,
	input  logic signed [COORD_WIDTH-1:0]     x,
	input  logic signed [COORD_WIDTH-1:0]     y,
	input  logic [rv2d_pkg::FRAC_W:0]         sin_in,
	input  logic [rv2d_pkg::FRAC_W:0]         cos_in,
	output logic                              strobe,
	output logic signed [COORD_WIDTH:0]       rot_x,
	output logic signed [COORD_WIDTH:0]       rot_y
);
	import rv2d_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam int unsigned ProdW = COORD_WIDTH + 32;
	localparam int unsigned SumW  = ProdW + 1;
	localparam logic signed [SumW-1:0] RoundHalf =
		{{(SumW-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

	logic [FRAC_W:0]        c_sel;
	logic [FRAC_W:0]        s_sel;
	logic signed [31:0]     c_pos;
	logic signed [31:0]     s_pos;
	logic signed [31:0]     cq;
	logic signed [31:0]     sq;
	logic signed [SumW-1:0] sum_x;
	logic signed [SumW-1:0] sum_y;

	logic                          vld_s22;
	logic signed [31:0]            cq_s22;
	logic signed [31:0]            sq_s22;
	logic signed [COORD_WIDTH-1:0] x_s22;
	logic signed [COORD_WIDTH-1:0] y_s22;
	logic                          vld_s23;
	logic signed [ProdW-1:0]       xc_s23;
	logic signed [ProdW-1:0]       ys_s23;
	logic signed [ProdW-1:0]       xs_s23;
	logic signed [ProdW-1:0]       yc_s23;
	logic                          vld_s24;
	logic signed [COORD_WIDTH:0]   rot_x_s24;
	logic signed [COORD_WIDTH:0]   rot_y_s24;

	// undo the octant fold, then place cosine and sine by quadrant
	always_comb begin
		c_sel = ctl.swap ? sin_in : cos_in;
		s_sel = ctl.swap ? cos_in : sin_in;
		c_pos = signed'(32'(c_sel));
		s_pos = signed'(32'(s_sel));
		case (ctl.quad)
			QUAD_0: begin
				cq = c_pos;
				sq = s_pos;
			end
			QUAD_1: begin
				cq = -s_pos;
				sq = c_pos;
			end
			QUAD_2: begin
				cq = -c_pos;
				sq = -s_pos;
			end
			QUAD_3: begin
				cq = s_pos;
				sq = -c_pos;
			end
			default: begin
				cq = '0;
				sq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s22 <= 1'b0;
			vld_s23 <= 1'b0;
			vld_s24 <= 1'b0;
		end else begin
			vld_s22 <= ctl.vld;
			vld_s23 <= vld_s22;
			vld_s24 <= vld_s23;
		end
	end

	always_ff @(posedge clk) begin
		cq_s22 <= cq;
		sq_s22 <= sq;
		x_s22  <= x;
		y_s22  <= y;
	end

	// form the four products in Q38
	always_ff @(posedge clk) begin
		xc_s23 <= ProdW'(x_s22) * ProdW'(cq_s22);
		ys_s23 <= ProdW'(y_s22) * ProdW'(sq_s22);
		xs_s23 <= ProdW'(x_s22) * ProdW'(sq_s22);
		yc_s23 <= ProdW'(y_s22) * ProdW'(cq_s22);
	end

	// add, round half up, drop the Q30 fraction
	always_comb begin
		sum_x = SumW'(xc_s23) - SumW'(ys_s23) + RoundHalf;
		sum_y = SumW'(xs_s23) + SumW'(yc_s23) + RoundHalf;
	end

	always_ff @(posedge clk) begin
		rot_x_s24 <= sum_x[COORD_WIDTH+FRAC_W:FRAC_W];
		rot_y_s24 <= sum_y[COORD_WIDTH+FRAC_W:FRAC_W];
	end

	assign strobe = vld_s24;
	assign rot_x  = rot_x_s24;
	assign rot_y  = rot_y_s24;

endmodule

>>> hw/rtl/rv2d_checker.sv
// Port-level checks for vector_rotate_2d_core, attached by the bind below.
// Depends on rv2d_pkg for the pipeline latency.
module rv2d_checker #(
	parameter int unsigned COORD_WIDTH = 16,
	parameter int unsigned ANGLE_WIDTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic signed [COORD_WIDTH-1:0] vec_x,
	input logic signed [COORD_WIDTH-1:0] vec_y,
	input logic [ANGLE_WIDTH-1:0]        angle,
	input logic                          done,
	input logic signed [COORD_WIDTH:0]   rot_x,
	input logic signed [COORD_WIDTH:0]   rot_y
);
	import rv2d_pkg::*;

	localparam logic [ANGLE_WIDTH-1:0] QuarterTurn = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

	// the pipeline never holds off the sender
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every item gives one done pulse after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after accepted item");

	// no done pulse without an item that far back
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted item");

	// zero angle passes the vector through unchanged
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && angle == '0) |-> ##LATENCY
		(rot_x == {$past(vec_x[COORD_WIDTH-1], LATENCY), $past(vec_x, LATENCY)} &&
		 rot_y == {$past(vec_y[COORD_WIDTH-1], LATENCY), $past(vec_y, LATENCY)}))
		else $error("zero rotation changed the vector");

	// a quarter turn maps (x, y) to (-y, x)
	a_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && angle == QuarterTurn) |-> ##LATENCY
		(rot_x == -{$past(vec_y[COORD_WIDTH-1], LATENCY), $past(vec_y, LATENCY)} &&
		 rot_y == {$past(vec_x[COORD_WIDTH-1], LATENCY), $past(vec_x, LATENCY)}))
		else $error("quarter turn wrong");

endmodule

bind vector_rotate_2d_core rv2d_checker #(
	.COORD_WIDTH (COORD_WIDTH),
	.ANGLE_WIDTH (ANGLE_WIDTH)
) u_rv2d_checker (.*);

>>> bench/tb.sv
// Self-checking bench for vector_rotate_2d_core: directed corner vectors and angles,
// then random streams under several input gap patterns, checked against a local model.
// Depends on rv2d_pkg (pipeline latency) and the vector_rotate_2d_core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rv2d_pkg::LATENCY;

	localparam int unsigned CW = 16;
	localparam int unsigned AW = 16;
	localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
	localparam logic [63:0] HALF_Q30_64 = 64'd1 << 29;
	localparam logic [63:0] PI_2_Q30 = 64'd1686629713;
	localparam int unsigned REPORT_MAX = 10;

	typedef struct {
		logic signed [CW:0] x;
		logic signed [CW:0] y;
	} rotated_t;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start  = 1'b0;
	logic signed [CW-1:0] vec_x  = '0;
	logic signed [CW-1:0] vec_y  = '0;
	logic [AW-1:0]        angle  = '0;
	logic                 busy;
	logic                 done;
	logic signed [CW:0]   rot_x;
	logic signed [CW:0]   rot_y;

	rotated_t    pending_rot[$];
	int unsigned mismatch_cnt = 0;
	int unsigned idle_pct = 0;

	vector_rotate_2d_core #(
		.COORD_WIDTH(CW),
		.ANGLE_WIDTH(AW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.vec_x(vec_x),
		.vec_y(vec_y),
		.angle(angle),
		.done(done),
		.rot_x(rot_x),
		.rot_y(rot_y)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one Horner step of the Taylor series in Q30
	function automatic logic [63:0] series_step(input logic [63:0] t2, input logic [63:0] acc,
			input logic [63:0] k);
		return ONE_Q30 - (((t2 * acc) >> 30) / k);
	endfunction

	// rotate (x, y) by a binary angle with the same Q30 sine/cosine arithmetic as the block
	function automatic rotated_t predict_rotation(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic [AW-1:0] ang);
		logic [31:0]   phase;
		logic [1:0]    quad;
		logic [63:0]   u, v, t, t2, acc, sin_q, cos_q;
		logic          swap;
		longint        c, s, cq, sq, xl, yl, sum_x, sum_y;
		rotated_t      res;
		phase = {ang, {(32-AW){1'b0}}};
		quad  = phase[31:30];
		u     = {34'd0, phase[29:0]};
		swap  = u > HALF_Q30_64;
		v     = swap ? (ONE_Q30 - u) : u;
		t     = (v * PI_2_Q30 + HALF_Q30_64) >> 30;
		t2    = (t * t) >> 30;
		// sine series, then scale by t
		acc = ONE_Q30;
		acc = series_step(t2, acc, 64'd110);
		acc = series_step(t2, acc, 64'd72);
		acc = series_step(t2, acc, 64'd42);
		acc = series_step(t2, acc, 64'd20);
		acc = series_step(t2, acc, 64'd6);
		sin_q = (t * acc) >> 30;
		// cosine series
		acc = ONE_Q30;
		acc = series_step(t2, acc, 64'd132);
		acc = series_step(t2, acc, 64'd90);
		acc = series_step(t2, acc, 64'd56);
		acc = series_step(t2, acc, 64'd30);
		acc = series_step(t2, acc, 64'd12);
		acc = series_step(t2, acc, 64'd2);
		cos_q = acc;
		s = swap ? longint'(cos_q) : longint'(sin_q);
		c = swap ? longint'(sin_q) : longint'(cos_q);
		// map the first-quadrant pair onto the real quadrant
		case (quad)
			2'd0: begin cq = c;  sq = s;  end
			2'd1: begin cq = -s; sq = c;  end
			2'd2: begin cq = -c; sq = -s; end
			default: begin cq = s;  sq = -c; end
		endcase
		xl    = longint'(x);
		yl    = longint'(y);
		sum_x = (xl * cq - yl * sq + 64'sd536870912) >>> 30;
		sum_y = (xl * sq + yl * cq + 64'sd536870912) >>> 30;
		res.x = sum_x[CW:0];
		res.y = sum_y[CW:0];
		return res;
	endfunction

	task automatic note_mismatch(input string what, input logic signed [CW:0] exp_v,
			input logic signed [CW:0] act_v);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_MAX)
			$display("[%0t] mismatch %s: expected %0d actual %0d", $realtime, what, exp_v, act_v);
	endtask

	// compare each result against the oldest prediction
	always @(posedge clk) begin
		rotated_t want;
		if (arst_n && done) begin
			if (pending_rot.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX)
					$display("[%0t] result with no item outstanding: rot_x %0d rot_y %0d",
						$realtime, rot_x, rot_y);
			end else begin
				want = pending_rot.pop_front();
				if (rot_x !== want.x)
					note_mismatch("rot_x", want.x, rot_x);
				if (rot_y !== want.y)
					note_mismatch("rot_y", want.y, rot_y);
			end
		end
	end

	// present one item, hold it until taken, then queue its prediction
	task automatic send_item(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
			input logic [AW-1:0] ang);
		int unsigned gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(LATENCY + 2, 1) : $urandom_range(3, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		angle <= ang;
		do @(posedge clk); while (busy !== 1'b0);
		pending_rot.push_back(predict_rotation(x, y, ang));
	endtask

	function automatic logic signed [CW-1:0] pick_coord();
		case ($urandom_range(9))
			0: return {1'b1, {(CW-1){1'b0}}};
			1: return {1'b0, {(CW-1){1'b1}}};
			2: return '0;
			3: return '1;
			4: return CW'($signed($urandom_range(511)) - 256);
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic [AW-1:0] pick_angle();
		logic [AW-1:0] oct;
		case ($urandom_range(9))
			0, 1: begin
				// land on or right next to an octant boundary
				oct = AW'($urandom_range(7)) << (AW - 3);
				return oct + AW'($signed($urandom_range(2)) - 1);
			end
			default: return AW'($urandom);
		endcase
	endfunction

	task automatic run_random(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_item(pick_coord(), pick_coord(), pick_angle());
	endtask

	// corner vectors, quadrant and octant angles, zero angle
	task automatic test_directed();
		idle_pct = 0;
		send_item(16'sh0100, 16'sh0000, 16'h0000);
		send_item(16'sh7FFF, 16'sh7FFF, 16'h0000);
		send_item(-16'sh8000, -16'sh8000, 16'h0000);
		send_item(16'sh0100, 16'sh0200, 16'h4000);
		send_item(16'sh0100, 16'sh0200, 16'h8000);
		send_item(16'sh0100, 16'sh0200, 16'hC000);
		send_item(16'sh7FFF, -16'sh8000, 16'h4000);
		send_item(16'sh0100, 16'sh0000, 16'h2000);
		send_item(16'sh0100, 16'sh0000, 16'h2001);
		send_item(16'sh0100, 16'sh0000, 16'h1FFF);
		send_item(16'sh0100, 16'sh0100, 16'h0001);
		send_item(16'sh0100, 16'sh0100, 16'hFFFF);
		send_item(16'sh1234, -16'sh0567, 16'h6000);
		send_item(16'sh1234, -16'sh0567, 16'hA000);
		send_item(16'sh1234, -16'sh0567, 16'hE000);
		send_item(-16'sh8000, -16'sh8000, 16'h2000);
		send_item(16'sh7FFF, 16'sh7FFF, 16'hE000);
		send_item(-16'sh8000, 16'sh7FFF, 16'h6000);
		send_item(16'sh0000, 16'sh0000, 16'h1234);
		send_item(16'sh5555, 16'shAAAA - 16'sh0, 16'h5555);
		send_item(16'shAAAA, 16'sh5555, 16'hAAAA);
		send_item(-16'sh0001, 16'sh0001, 16'h7FFF);
		send_item(16'sh0001, -16'sh0001, 16'h8001);
	endtask

	task automatic test_back_to_back();
		idle_pct = 0;
		run_random(130);
	endtask

	task automatic test_sparse_input();
		idle_pct = 59;
		run_random(130);
	endtask

	task automatic test_steady_stream();
		// the output side cannot stall, so keep the input saturated here
		idle_pct = 0;
		run_random(110);
	endtask

	task automatic test_mixed_gaps();
		idle_pct = 23;
		run_random(130);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_sparse_input();
		test_steady_stream();
		test_mixed_gaps();
		start <= 1'b0;
		// drain the pipeline, then give it a little extra time
		for (int unsigned i = 0; i < 4 * LATENCY && pending_rot.size() != 0; i++)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		if (pending_rot.size() != 0) begin
			mismatch_cnt++;
			$display("%0d items never produced a result", pending_rot.size());
		end
		if (mismatch_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// stop a hung run
	initial begin
		#400us;
		$display("status: fail");
		$finish;
	end

endmodule
